/* hdl/opoq_pkg.sv */
package opoq_pkg;

	localparam int STORE_AW = 15;
	localparam int STORE_DW = 14;
	localparam int COORD_W  = 4;
	localparam int POS_W    = 16;
	localparam int STEP_W   = 14;

	localparam logic signed [POS_W-1:0] Q_ONE     = 16'sd16384;
	localparam logic signed [POS_W-1:0] Q_NEG_ONE = -16'sd16384;
	localparam logic [STEP_W-1:0]       Q_HALF    = 14'd8192;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [1:0] KIND_EMPTY   = 2'd0;
	localparam logic [1:0] KIND_INNER   = 2'd1;
	localparam logic [1:0] KIND_LEAF    = 2'd2;
	// The spare code behaves as an inner node.
	localparam logic [1:0] KIND_UNKNOWN = 2'd3;

	typedef struct packed {
		logic                    cmd;
		logic [STORE_AW-1:0]     entry_index;
		logic [COORD_W-1:0]      child_x;
		logic [COORD_W-1:0]      child_y;
		logic [COORD_W-1:0]      child_z;
		logic [1:0]              node_kind;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
	} req_t;

	typedef struct packed {
		logic is_solid;
		logic outside;
	} rsp_t;

	// Texel layout: kind in the top two bits, then child z, y, x.
	typedef struct packed {
		logic [1:0]         kind;
		logic [COORD_W-1:0] cz;
		logic [COORD_W-1:0] cy;
		logic [COORD_W-1:0] cx;
	} texel_t;

endpackage

/* hdl/octree_point_occupancy_query.sv */
// Octree point occupancy query over a 2x2x2-cell indirection store.
//
// A request is taken at a rising edge where start is high and busy is low.
// A write request (cmd = 0) stores one texel; a query request (cmd = 1)
// tests a signed Q2.14 point against the octree held in the store.
// Every request gives exactly one response: done is high for one cycle with
// rsp valid in that cycle. The receiver cannot stall, so nothing waits on it.
//
// A write or an outside point answers in the cycle after it is taken, and
// busy stays low. A query inside [-1, 1] on every axis walks the tree with one
// dependent read of the 32768 x 14 synchronous texel memory per level and
// holds busy high until it answers; that read loop alone sets the query rate.
// A new request may be taken in the cycle in which done is high.
//
// Reset clears the control state only. The texel memory is not cleared and
// must be written before the texels that queries reach are read.
module octree_point_occupancy_query
	import opoq_pkg::*;
#(
	parameter int TEX_SIDE     = 32,
	parameter int DEPTH_LEVELS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	localparam int SIDE_LOG = $clog2(TEX_SIDE);
	localparam int LVL_W    = (DEPTH_LEVELS + 1 > 1) ? $clog2(DEPTH_LEVELS + 1) : 1;
	localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(DEPTH_LEVELS);

	typedef enum logic {
		ST_IDLE,
		ST_LOOK
	} state_t;

	state_t state_q;

	logic signed [POS_W-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic signed [POS_W-1:0] cen_x_q, cen_y_q, cen_z_q;
	logic [STEP_W-1:0]       step_q;
	logic [2:0]              sel_q;
	logic [LVL_W-1:0]        level_q;

	texel_t texel_mem [2**STORE_AW];
	texel_t rdata_q;

	logic                    wr_en;
	logic                    rd_en;
	logic [STORE_AW-1:0]     rd_addr;
	texel_t                  wdata;
	logic                    req_take;
	logic                    req_outside;
	logic signed [POS_W-1:0] step_s;
	logic signed [POS_W-1:0] nx_cen_x, nx_cen_y, nx_cen_z;
	logic [2:0]              sel_idle, sel_next;
	logic                    inner_go;

	function automatic logic [STORE_AW-1:0] flat_index(
		input logic [COORD_W-1:0] cx,
		input logic [COORD_W-1:0] cy,
		input logic [COORD_W-1:0] cz,
		input logic [2:0]         sel
	);
		logic [STORE_AW-1:0] x, y, z;
		x = STORE_AW'({cx, sel[0]});
		y = STORE_AW'({cy, sel[1]});
		z = STORE_AW'({cz, sel[2]});
		return x + (y << SIDE_LOG) + (z << (2 * SIDE_LOG));
	endfunction

	assign busy     = (state_q != ST_IDLE);
	assign req_take = start && !busy;

	assign req_outside = (req.pos_x > Q_ONE) || (req.pos_x < Q_NEG_ONE) ||
	                     (req.pos_y > Q_ONE) || (req.pos_y < Q_NEG_ONE) ||
	                     (req.pos_z > Q_ONE) || (req.pos_z < Q_NEG_ONE);

	// Octant at the root: the centre is zero.
	assign sel_idle = {req.pos_z > 16'sd0, req.pos_y > 16'sd0, req.pos_x > 16'sd0};

	assign step_s   = $signed({2'b00, step_q});
	assign nx_cen_x = sel_q[0] ? cen_x_q + step_s : cen_x_q - step_s;
	assign nx_cen_y = sel_q[1] ? cen_y_q + step_s : cen_y_q - step_s;
	assign nx_cen_z = sel_q[2] ? cen_z_q + step_s : cen_z_q - step_s;
	assign sel_next = {pos_z_q > nx_cen_z, pos_y_q > nx_cen_y, pos_x_q > nx_cen_x};

	// Unknown kind codes descend like inner nodes.
	assign inner_go = (state_q == ST_LOOK) && (rdata_q.kind != KIND_LEAF) &&
	                  (rdata_q.kind != KIND_EMPTY) && (level_q != LVL_LAST);

	assign wr_en = req_take && (req.cmd == CMD_WRITE);
	assign wdata = '{kind: req.node_kind, cz: req.child_z, cy: req.child_y,
	                 cx: req.child_x};

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = flat_index('0, '0, '0, sel_idle);
		if (state_q == ST_IDLE) begin
			rd_en = req_take && (req.cmd == CMD_QUERY) && !req_outside;
		end else begin
			rd_en   = inner_go;
			rd_addr = flat_index(rdata_q.cx, rdata_q.cy, rdata_q.cz, sel_next);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			texel_mem[req.entry_index] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= texel_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			done         <= 1'b0;
			rsp          <= '0;
			pos_x_q      <= '0;
			pos_y_q      <= '0;
			pos_z_q      <= '0;
			cen_x_q      <= '0;
			cen_y_q      <= '0;
			cen_z_q      <= '0;
			step_q       <= '0;
			sel_q        <= '0;
			level_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					done <= req_take && ((req.cmd == CMD_WRITE) || req_outside);
					if (req_take) begin
						if (req.cmd == CMD_WRITE) begin
							rsp  <= '{is_solid: 1'b0, outside: 1'b0};
						end else if (req_outside) begin
							rsp  <= '{is_solid: 1'b0, outside: 1'b1};
						end else begin
							state_q <= ST_LOOK;
							pos_x_q <= req.pos_x;
							pos_y_q <= req.pos_y;
							pos_z_q <= req.pos_z;
							cen_x_q <= '0;
							cen_y_q <= '0;
							cen_z_q <= '0;
							step_q  <= Q_HALF;
							sel_q   <= sel_idle;
							level_q <= '0;
						end
					end
				end
				ST_LOOK: begin
					done <= !inner_go;
					if (inner_go) begin
						cen_x_q <= nx_cen_x;
						cen_y_q <= nx_cen_y;
						cen_z_q <= nx_cen_z;
						step_q  <= step_q >> 1;
						sel_q   <= sel_next;
						level_q <= level_q + LVL_W'(1);
					end else begin
						state_q <= ST_IDLE;
						rsp     <= '{is_solid: (rdata_q.kind == KIND_LEAF), outside: 1'b0};
					end
				end
				default: begin
					state_q <= ST_IDLE;
					done    <= 1'b0;
				end
			endcase
		end
	end

endmodule
